// ===== rtl/pll_frequency_plan_sequencer_unit_assert.svh =====
// Assertion macros used by the checker of the PLL frequency plan sequencer.
`ifndef PLL_FREQUENCY_PLAN_SEQUENCER_UNIT_ASSERT_SVH
`define PLL_FREQUENCY_PLAN_SEQUENCER_UNIT_ASSERT_SVH

// Property checked on every rising edge outside of reset.
`define PFPS_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Property checked on every rising edge, during reset as well.
`define PFPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== rtl/pfps_pkg.sv =====
// Shared types, constants and widths of the PLL frequency plan sequencer.
package pfps_pkg;

  // Field widths.
  localparam int unsigned FreqW   = 35;
  localparam int unsigned RefW    = 30;
  localparam int unsigned PfdW    = RefW + 1;
  localparam int unsigned ScanW   = FreqW + 7;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned DataW   = 16;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned PowerW  = 3;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned MuxW    = 2;
  localparam int unsigned CfgIdxW = 2;

  // Fraction denominator and the widths that follow from it.
  localparam int unsigned FracDen    = 1000;
  localparam int unsigned FracDen2W  = $clog2(2 * FracDen + 1);
  localparam logic [FracDen2W-1:0] FracDen2 = FracDen2W'(2 * FracDen);
  localparam int unsigned AccW       = PfdW + FracDen2W;
  localparam int unsigned FracShift  = $clog2(FracDen + 1);

  // Bit-serial divider widths.
  localparam int unsigned DvdW = FreqW;
  localparam int unsigned DivW = PfdW + 1;
  localparam int unsigned QuoW = DataW;
  localparam int unsigned CntW = $clog2(DvdW + 1);

  // Command codes.
  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_FAST  = 2'd1,
    CMD_PWR_A = 2'd2,
    CMD_PWR_B = 2'd3
  } pfps_cmd_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRefClock = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVcoMin   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVcoMax   = 2'd2;

  // Configuration reset values.
  localparam logic [RefW-1:0]  RefClockRst = RefW'(100000000);
  localparam logic [FreqW-1:0] VcoMinRst   = FreqW'(64'd5650000000);
  localparam logic [FreqW-1:0] VcoMaxRst   = FreqW'(64'd11300000000);

  // Output path select codes.
  localparam logic [MuxW-1:0] MuxDivider = 2'd0;
  localparam logic [MuxW-1:0] MuxVco     = 2'd1;
  localparam logic [MuxW-1:0] MuxDoubler = 2'd2;

  localparam logic [CodeW-1:0]  CodeNone = 3'd7;
  localparam logic [PowerW-1:0] PowerMax = 3'd7;

  // PLL register addresses.
  localparam logic [AddrW-1:0] AddrCal   = 7'h2C;
  localparam logic [AddrW-1:0] AddrN     = 7'h24;
  localparam logic [AddrW-1:0] AddrNumLo = 7'h2B;
  localparam logic [AddrW-1:0] AddrR80   = 7'h50;
  localparam logic [AddrW-1:0] AddrR79   = 7'h4F;
  localparam logic [AddrW-1:0] AddrR78   = 7'h4E;
  localparam logic [AddrW-1:0] AddrNumHi = 7'h2A;
  localparam logic [AddrW-1:0] AddrDenLo = 7'h27;
  localparam logic [AddrW-1:0] AddrDenHi = 7'h26;
  localparam logic [AddrW-1:0] AddrChDiv = 7'h20;
  localparam logic [AddrW-1:0] AddrR0    = 7'h00;

  // Fixed register contents.
  localparam logic [DataW-1:0] DataCal   = 16'h8000;
  localparam logic [DataW-1:0] DataR0    = 16'h6070;
  localparam logic [DataW-1:0] ChDivBase = 16'h1001;

  // Write slots of a frequency command, in emission order.
  typedef enum logic [3:0] {
    SL_CAL, SL_N, SL_NUM_LO, SL_R80, SL_R79, SL_R78,
    SL_NUM_HI, SL_DEN_LO, SL_DEN_HI, SL_CHDIV, SL_R0
  } pfps_slot_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_N_GO, ST_N_RUN, ST_ADD, ST_F_GO, ST_F_RUN, ST_EMIT
  } pfps_state_e;

  // Divider start request.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] rem_init;
    logic [DvdW-1:0] dvd_init;
    logic [DivW-1:0] divisor;
    logic [CntW-1:0] count;
  } pfps_div_cmd_t;

  // Divider status.
  typedef struct packed {
    logic            busy;
    logic [QuoW-1:0] quotient;
    logic [DivW-1:0] remainder;
  } pfps_div_sts_t;

  // One register write offered to the output stage.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic             last;
  } pfps_wr_t;

endpackage

// ===== rtl/pfps_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module pfps_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pfps_pkg::pfps_div_cmd_t cmd_i,
  output pfps_pkg::pfps_div_sts_t sts_o
);
  import pfps_pkg::*;

  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dsr_q, dsr_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW:0]   trial;
  logic            fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    fits  = (trial >= {1'b0, dsr_q});
    dvd_d = dvd_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      dvd_d = cmd_i.dvd_init;
      rem_d = cmd_i.rem_init;
      dsr_d = cmd_i.divisor;
      quo_d = '0;
      cnt_d = cmd_i.count;
    end else if (cnt_q != '0) begin
      dvd_d = dvd_q << 1;
      rem_d = fits ? DivW'(trial - {1'b0, dsr_q}) : trial[DivW-1:0];
      quo_d = {quo_q[QuoW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy      = (cnt_q != '0);
  assign sts_o.quotient  = quo_q;
  assign sts_o.remainder = rem_q;

endmodule

// ===== rtl/pfps_seq.sv =====
// Plan sequencer: path choice, division control and the register write list.
module pfps_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [pfps_pkg::RefW-1:0]      osc_hz_i,
  input  logic [pfps_pkg::FreqW-1:0]     vco_min_hz_i,
  input  logic [pfps_pkg::FreqW-1:0]     vco_max_hz_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     command_i,
  input  logic [pfps_pkg::FreqW-1:0]     target_hz_i,
  input  logic                           use_channel_a_i,
  input  logic [pfps_pkg::LevelW-1:0]    power_level_i,
  output pfps_pkg::pfps_div_cmd_t        div_cmd_o,
  input  pfps_pkg::pfps_div_sts_t        div_sts_i,
  output pfps_pkg::pfps_wr_t             wr_o,
  input  logic                           wr_ready_i
);
  import pfps_pkg::*;

  pfps_state_e            state_q, state_d;
  pfps_slot_e             idx_q, idx_d;
  logic                   single_q, single_d;
  logic                   b_side_q, b_side_d;
  logic                   a_pd_q, a_pd_d, b_pd_q, b_pd_d;
  logic [MuxW-1:0]        mux_q, mux_d;
  logic [PowerW-1:0]      a_pwr_q, a_pwr_d, b_pwr_q, b_pwr_d;
  logic [CodeW-1:0]       code_q, code_d;
  logic [FreqW-1:0]       vco_q, vco_d;
  logic [ScanW-1:0]       scan_q, scan_d;
  logic [CodeW-1:0]       scan_cnt_q, scan_cnt_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [DataW-1:0]       n_q, n_d, num_q, num_d;
  logic [PfdW-1:0]        pfd;
  logic                   ref_zero, below_min, above_max, scan_hit, emit_last;
  logic [PowerW-1:0]      level_sat;

  assign pfd       = {osc_hz_i, 1'b0};
  assign ref_zero  = (osc_hz_i == '0);
  assign below_min = (target_hz_i < vco_min_hz_i);
  assign above_max = (target_hz_i > vco_max_hz_i);
  assign scan_hit  = (scan_q < ScanW'(vco_max_hz_i));
  assign level_sat = (power_level_i > LevelW'(PowerMax)) ? PowerMax : power_level_i[PowerW-1:0];
  assign emit_last = single_q || (idx_q == SL_R0);
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_PWR_A || command_i == CMD_PWR_B) begin
            state_d = ST_EMIT;
          end else if (below_min) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_N_GO;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_cnt_q == CodeW'(1)) state_d = ST_N_GO;
      end
      ST_N_GO:  state_d = ref_zero ? ST_EMIT : ST_N_RUN;
      ST_N_RUN: if (!div_sts_i.busy) state_d = ST_ADD;
      ST_ADD:   state_d = ST_F_GO;
      ST_F_GO:  state_d = ST_F_RUN;
      ST_F_RUN: if (!div_sts_i.busy) state_d = ST_EMIT;
      ST_EMIT:  if (wr_ready_i && emit_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Plan datapath.
  always_comb begin
    idx_d      = idx_q;
    single_d   = single_q;
    a_pd_d     = a_pd_q;
    b_pd_d     = b_pd_q;
    mux_d      = mux_q;
    a_pwr_d    = a_pwr_q;
    b_pwr_d    = b_pwr_q;
    code_d     = code_q;
    vco_d      = vco_q;
    scan_d     = scan_q;
    scan_cnt_d = scan_cnt_q;
    acc_d      = acc_q;
    n_d        = n_q;
    num_d      = num_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = SL_CAL;
        if (in_valid_i) begin
          case (command_i) inside
            CMD_PWR_A, CMD_PWR_B: begin
              single_d = 1'b1;
              if (command_i == CMD_PWR_A) a_pwr_d = level_sat;
              else                        b_pwr_d = level_sat;
            end
            default: begin
              single_d = 1'b0;
              if (command_i == CMD_SET) begin
                a_pd_d = !use_channel_a_i;
                b_pd_d = use_channel_a_i;
              end
              // Path choice: divider below the minimum, doubler above the maximum.
              code_d     = CodeNone;
              vco_d      = target_hz_i;
              scan_d     = {target_hz_i, 7'b0};
              scan_cnt_d = CodeW'(7);
              if (below_min)      mux_d = MuxDivider;
              else if (above_max) begin
                mux_d = MuxDoubler;
                vco_d = target_hz_i >> 1;
              end else            mux_d = MuxVco;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Try the dividers from 128 down to 2, one per cycle.
        if (scan_hit) begin
          vco_d  = scan_q[FreqW-1:0];
          code_d = scan_cnt_q - 1'b1;
        end else begin
          scan_d     = scan_q >> 1;
          scan_cnt_d = scan_cnt_q - 1'b1;
        end
      end
      ST_N_GO: begin
        if (ref_zero) begin
          n_d   = '0;
          num_d = '0;
        end
      end
      ST_N_RUN: begin
        // Quotient is N; the remainder is scaled for the rounded fraction.
        if (!div_sts_i.busy) begin
          n_d   = div_sts_i.quotient;
          acc_d = AccW'(div_sts_i.remainder[PfdW-1:0]) * AccW'(FracDen2);
        end
      end
      ST_ADD:   acc_d = acc_q + AccW'(pfd);
      ST_F_GO:  ;
      ST_F_RUN: if (!div_sts_i.busy) num_d = div_sts_i.quotient;
      ST_EMIT:  if (wr_ready_i && !emit_last) idx_d = pfps_slot_e'(idx_q + 4'd1);
      default:  ;
    endcase
  end

  // Divider requests.
  always_comb begin
    div_cmd_o = '0;
    unique case (state_q)
      ST_N_GO: begin
        div_cmd_o.start    = !ref_zero;
        div_cmd_o.rem_init = '0;
        div_cmd_o.dvd_init = vco_q;
        div_cmd_o.divisor  = DivW'(pfd);
        div_cmd_o.count    = CntW'(FreqW);
      end
      ST_F_GO: begin
        // The top bits of the scaled remainder are already below the divisor.
        div_cmd_o.start    = 1'b1;
        div_cmd_o.rem_init = DivW'(acc_q >> FracShift);
        div_cmd_o.dvd_init = DvdW'(acc_q[FracShift-1:0]) << (DvdW - FracShift);
        div_cmd_o.divisor  = {pfd, 1'b0};
        div_cmd_o.count    = CntW'(FracShift);
      end
      default: ;
    endcase
  end

  // Write beat offered to the output stage.
  always_comb begin
    wr_o       = '0;
    wr_o.valid = (state_q == ST_EMIT);
    wr_o.last  = emit_last;
    if (single_q) begin
      wr_o.addr = b_side_q ? AddrR80 : AddrR79;
      wr_o.data = b_side_q ? {7'b0, b_pwr_q, 6'b0}
                           : {7'b0, b_pd_q, 2'b0, mux_q, a_pwr_q, 1'b0};
    end else begin
      unique case (idx_q)
        SL_CAL:    begin wr_o.addr = AddrCal;   wr_o.data = DataCal; end
        SL_N:      begin wr_o.addr = AddrN;     wr_o.data = n_q; end
        SL_NUM_LO: begin wr_o.addr = AddrNumLo; wr_o.data = num_q; end
        SL_R80:    begin wr_o.addr = AddrR80;   wr_o.data = {7'b0, b_pwr_q, 6'b0}; end
        SL_R79: begin
          wr_o.addr = AddrR79;
          wr_o.data = {7'b0, b_pd_q, 2'b0, mux_q, a_pwr_q, 1'b0};
        end
        SL_R78:    begin wr_o.addr = AddrR78;   wr_o.data = {11'b0, a_pd_q, 2'b0, mux_q}; end
        // The fraction never exceeds the denominator, so its upper word is zero.
        SL_NUM_HI: begin wr_o.addr = AddrNumHi; wr_o.data = '0; end
        SL_DEN_LO: begin wr_o.addr = AddrDenLo; wr_o.data = DataW'(FracDen); end
        SL_DEN_HI: begin wr_o.addr = AddrDenHi; wr_o.data = DataW'(FracDen >> 16); end
        SL_CHDIV: begin
          wr_o.addr = AddrChDiv;
          wr_o.data = {4'b0, code_q, code_q, 6'b0} | ChDivBase;
        end
        SL_R0:     begin wr_o.addr = AddrR0;    wr_o.data = DataR0; end
        default:   begin wr_o.addr = AddrR0;    wr_o.data = DataR0; end
      endcase
    end
  end

  // Which output a power command addressed.
  assign b_side_d = (state_q == ST_IDLE && in_valid_i) ? (command_i == CMD_PWR_B) : b_side_q;

  // Control and plan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      a_pd_q   <= 1'b0;
      b_pd_q   <= 1'b0;
      mux_q    <= MuxDivider;
      a_pwr_q  <= PowerMax;
      b_pwr_q  <= PowerMax;
      single_q <= 1'b0;
      idx_q    <= SL_CAL;
    end else begin
      state_q  <= state_d;
      a_pd_q   <= a_pd_d;
      b_pd_q   <= b_pd_d;
      mux_q    <= mux_d;
      a_pwr_q  <= a_pwr_d;
      b_pwr_q  <= b_pwr_d;
      single_q <= single_d;
      idx_q    <= idx_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    b_side_q   <= b_side_d;
    code_q     <= code_d;
    vco_q      <= vco_d;
    scan_q     <= scan_d;
    scan_cnt_q <= scan_cnt_d;
    acc_q      <= acc_d;
    n_q        <= n_d;
    num_q      <= num_d;
  end

endmodule

// ===== rtl/pll_frequency_plan_sequencer_unit.sv =====
// Top level of the PLL frequency plan sequencer: configuration, sequencer, divider, output stage.
// A power command produces a single output beat; no further input is taken until the output stage takes it.
// A frequency command runs the divider search (only below the VCO minimum), the N division, the
// fraction division and 11 output beats; with a zero reference both divisions are skipped.
// Output stalls hold the sequencer while a beat waits to be taken.
// Reset (rst_ni low, asynchronous) restores the configuration defaults and the power state.
module pll_frequency_plan_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [34:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // target_hz[34:0], use_channel_a[35], power_level[43:36]
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // reg_address[6:0], reg_data[22:7]
  output logic        m_axis_tlast_o   // last_write
);
  import pfps_pkg::*;

  logic [RefW-1:0]  osc_hz_q;
  logic [FreqW-1:0] vco_min_q, vco_max_q;
  pfps_div_cmd_t    div_cmd;
  pfps_div_sts_t    div_sts;
  pfps_wr_t         wr;
  logic             out_ready;
  logic             out_valid_q;
  logic [AddrW-1:0] out_addr_q;
  logic [DataW-1:0] out_data_q;
  logic             out_last_q;

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_hz_q  <= RefClockRst;
      vco_min_q <= VcoMinRst;
      vco_max_q <= VcoMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRefClock: osc_hz_q  <= cfg_data_i[RefW-1:0];
        CfgVcoMin:   vco_min_q <= cfg_data_i;
        CfgVcoMax:   vco_max_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  pfps_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .osc_hz_i        (osc_hz_q),
    .vco_min_hz_i    (vco_min_q),
    .vco_max_hz_i    (vco_max_q),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .command_i       (s_axis_tuser_i),
    .target_hz_i     (s_axis_tdata_i[34:0]),
    .use_channel_a_i (s_axis_tdata_i[35]),
    .power_level_i   (s_axis_tdata_i[43:36]),
    .div_cmd_o       (div_cmd),
    .div_sts_i       (div_sts),
    .wr_o            (wr),
    .wr_ready_i      (out_ready)
  );

  pfps_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .sts_o  (div_sts)
  );

  // Output register: takes a new beat when empty or when the current one leaves.
  assign out_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= wr.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && wr.valid) begin
      out_addr_q <= wr.addr;
      out_data_q <= wr.data;
      out_last_q <= wr.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/pfps_checker.sv =====
// Port-level checks of the PLL frequency plan sequencer and their binding.
`include "pll_frequency_plan_sequencer_unit_assert.svh"

module pfps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_index_i,
  input logic [34:0] cfg_data_i,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // No output beat is offered in the cycle after an edge seen in reset.
  `PFPS_ASSERT_ALWAYS(a_no_beat_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o)

  // A stalled output beat keeps its payload and stays offered.
  `PFPS_ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // While a beat that is not the last one waits, the item is unfinished and no input is taken.
  `PFPS_ASSERT_CLK(a_busy_mid_item, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)

  // After an input beat is taken the block works on it before taking another.
  `PFPS_ASSERT_CLK(a_one_item, clk_i, rst_ni,
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)

endmodule

bind pll_frequency_plan_sequencer_unit pfps_checker u_pfps_checker (.*);
